// ===== design/assert_macros.svh =====
// Assertion macros shared by the lottery arbiter modules.
// Each macro expects signals named clk and rst in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the following cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/lta_pkg.sv =====
// Package for the lottery ticket arbiter: item structs, codes and fixed widths.
// No dependencies; imported by the top level and the modulo unit.
`timescale 1ns / 1ps

package lta_pkg;

  localparam int RND_W        = 16;
  localparam int SLOT_FIELD_W = 4;
  localparam int TICKET_W     = 7;
  localparam int POOL_W       = 11;
  localparam int POOL_MAX     = 2047;
  localparam int TICKET_MAX   = 127;
  localparam int CFG_INDEX_W  = 2;

  // Event codes.
  localparam logic [2:0] ACT_START_USER = 3'd0;
  localparam logic [2:0] ACT_START_SYS  = 3'd1;
  localparam logic [2:0] ACT_STOP       = 3'd2;
  localparam logic [2:0] ACT_EXPIRE     = 3'd3;
  localparam logic [2:0] ACT_NICE       = 3'd4;

  // Status codes.
  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_IN_USE = 2'd1;
  localparam logic [1:0] STAT_FREE   = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_START_TICKETS = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TICKET_STEP   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_TICKET_CAP    = 2'd2;

  // Register values after reset.
  localparam logic [TICKET_W-1:0] DEF_START_TICKETS = 7'd5;
  localparam logic [TICKET_W-1:0] DEF_TICKET_STEP   = 7'd1;
  localparam logic [TICKET_W-1:0] DEF_TICKET_CAP    = 7'd100;

  typedef struct packed {
    logic [2:0]              action;
    logic [SLOT_FIELD_W-1:0] slot;
    logic [RND_W-1:0]        random_value;
  } lta_in_t;

  typedef struct packed {
    logic                    winner_valid;
    logic [SLOT_FIELD_W-1:0] winner_slot;
    logic [POOL_W-1:0]       pool_tickets;
    logic [1:0]              status;
  } lta_out_t;

endpackage

// ===== design/lottery_ticket_arbiter.sv =====
// Lottery ticket arbiter top level: event sequencer, slot flags and register file.
// Depends on lta_pkg, lta_ram, lta_div and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// The arbiter keeps a table of SLOTS process slots and takes one scheduling event
// per item: start a user or system slot, stop it, expire its quantum, or nice it.
// Every event returns exactly one result item. Events that start a free slot,
// or expire or nice a slot in use, also run a lottery: the ticket counts of all
// waiting user slots are summed, a ticket is drawn as random_value modulo that
// sum plus one, and the slots are walked in index order until the drawn ticket
// is covered; that slot wins and leaves the waiting pool. Ticket counts live in a
// single-port-read RAM, so the sum and the walk each make one pass over the
// table, and the modulo is computed one bit per cycle over the 16 random bits.
// The walk stops early when the winner sits early in the table; an item rejected
// by a status check, a stop, or an undefined action goes from decode straight to
// the finish state. One item is worked on at a time, but a finished result waits
// in an output register, so the next item is accepted while the previous result
// is still pending. Configuration writes are always accepted and must only
// happen while the block is idle.
module lottery_ticket_arbiter #(
  parameter int SLOTS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  lta_pkg::lta_in_t                  in_item,
  output logic                              out_valid,
  input  logic                              out_ready,
  output lta_pkg::lta_out_t                 out_item,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lta_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [lta_pkg::TICKET_W-1:0]      cfg_data
);

  import lta_pkg::*;

  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int SUM_W = $clog2(SLOTS * TICKET_MAX + 1);
  localparam int EXT_W = IDX_W + SLOT_FIELD_W;
  localparam int SAT_W = SUM_W + POOL_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_MODIFY,
    ST_SUM,
    ST_CHECK,
    ST_DIV,
    ST_WALK,
    ST_FINISH
  } state_t;

  state_t state;

  // Configuration registers.
  logic [TICKET_W-1:0] start_tickets;
  logic [TICKET_W-1:0] ticket_step;
  logic [TICKET_W-1:0] ticket_cap;

  // Per-slot flags, cleared at once by reset.
  logic [SLOTS-1:0] in_use;
  logic [SLOTS-1:0] is_user;
  logic [SLOTS-1:0] waiting;

  // Current item, pass counters and lottery datapath.
  lta_in_t        item;
  lta_out_t       res;
  logic [CNT_W-1:0] cnt;
  logic [IDX_W-1:0] lag_idx;
  logic             lag_live;
  logic [SUM_W-1:0] total;
  logic [SUM_W-1:0] ticket;

  // RAM and modulo unit hookup.
  logic                ram_wr_en;
  logic [TICKET_W-1:0] ram_wr_data;
  logic [IDX_W-1:0]    ram_rd_addr;
  logic [TICKET_W-1:0] ram_rd_data;
  logic                div_start;
  logic                div_done;
  logic [SUM_W-1:0]    div_rem;

  // Decode of the held item.
  logic [EXT_W-1:0]    slot_ext;
  logic [IDX_W-1:0]    idx;
  logic                slot_ok;
  logic                act_defined;
  logic                act_start;
  logic                start_ok;
  logic                sel_in_use;
  logic                sel_user;
  logic [TICKET_W-1:0] mod_tickets;
  logic [TICKET_W:0]   nice_sum;
  logic                elig;
  logic                win;
  logic [EXT_W-1:0]    win_ext;
  logic [SAT_W-1:0]    total_ext;
  logic [POOL_W-1:0]   pool_sat;

  always_comb begin
    slot_ext    = {IDX_W'(0), item.slot};
    idx         = slot_ext[IDX_W-1:0];
    slot_ok     = slot_ext < EXT_W'(SLOTS);
    act_defined = item.action <= ACT_NICE;
    act_start   = (item.action == ACT_START_USER) || (item.action == ACT_START_SYS);
    sel_in_use  = slot_ok && in_use[idx];
    sel_user    = slot_ok && is_user[idx];
    start_ok    = act_defined && slot_ok && act_start && !sel_in_use;
  end

  // New ticket count for expiry (floor of one) and nice (capped).
  always_comb begin
    nice_sum = {1'b0, ram_rd_data} + {1'b0, ticket_step};
    if (item.action == ACT_EXPIRE) begin
      mod_tickets = (ram_rd_data > ticket_step) ? ram_rd_data - ticket_step
                                                : TICKET_W'(1);
    end else begin
      mod_tickets = (nice_sum > {1'b0, ticket_cap}) ? ticket_cap
                                                    : nice_sum[TICKET_W-1:0];
    end
  end

  // The RAM is written by a start in decode and by the expiry or nice update.
  always_comb begin
    ram_wr_en = ((state == ST_DECODE) && start_ok) || (state == ST_MODIFY);
    if (state == ST_MODIFY) begin
      ram_wr_data = mod_tickets;
    end else if (item.action == ACT_START_USER) begin
      ram_wr_data = start_tickets;
    end else begin
      ram_wr_data = '0;
    end
    if ((state == ST_SUM) || (state == ST_WALK)) begin
      ram_rd_addr = cnt[IDX_W-1:0];
    end else begin
      ram_rd_addr = idx;
    end
  end

  // The entry read in the previous cycle belongs to lag_idx.
  always_comb begin
    elig      = lag_live && is_user[lag_idx] && waiting[lag_idx];
    win       = elig && ({{(SUM_W - TICKET_W){1'b0}}, ram_rd_data} >= ticket);
    win_ext   = {SLOT_FIELD_W'(0), lag_idx};
    total_ext = {POOL_W'(0), total};
    pool_sat  = (total_ext > SAT_W'(POOL_MAX)) ? POOL_W'(POOL_MAX)
                                               : total_ext[POOL_W-1:0];
    div_start = (state == ST_CHECK) && (total != '0);
  end

  assign in_ready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;

  lta_ram #(
    .DEPTH (SLOTS),
    .AW    (IDX_W),
    .DW    (TICKET_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (idx),
    .wr_data (ram_wr_data),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  lta_div #(
    .DIVISOR_W (SUM_W)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (item.random_value),
    .divisor   (total),
    .done      (div_done),
    .remainder (div_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      start_tickets <= DEF_START_TICKETS;
      ticket_step   <= DEF_TICKET_STEP;
      ticket_cap    <= DEF_TICKET_CAP;
      in_use        <= '0;
      is_user       <= '0;
      waiting       <= '0;
      out_valid     <= 1'b0;
      lag_live      <= 1'b0;
      cnt           <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_START_TICKETS: start_tickets <= cfg_data;
          REG_TICKET_STEP:   ticket_step   <= cfg_data;
          REG_TICKET_CAP:    ticket_cap    <= cfg_data;
          default: ;
        endcase
      end

      // The output register fills from the finish state and empties when taken.
      if ((state == ST_FINISH) && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            item  <= in_item;
            res   <= '0;
            state <= ST_DECODE;
          end
        end

        ST_DECODE: begin
          cnt      <= '0;
          lag_live <= 1'b0;
          total    <= '0;
          if (!act_defined) begin
            state <= ST_FINISH;
          end else if (!slot_ok) begin
            res.status <= STAT_FREE;
            state      <= ST_FINISH;
          end else if (act_start) begin
            if (sel_in_use) begin
              res.status <= STAT_IN_USE;
              state      <= ST_FINISH;
            end else begin
              in_use[idx]  <= 1'b1;
              is_user[idx] <= (item.action == ACT_START_USER);
              waiting[idx] <= (item.action == ACT_START_USER);
              state        <= ST_SUM;
            end
          end else if (!sel_in_use) begin
            res.status <= STAT_FREE;
            state      <= ST_FINISH;
          end else if (item.action == ACT_STOP) begin
            in_use[idx]  <= 1'b0;
            is_user[idx] <= 1'b0;
            waiting[idx] <= 1'b0;
            state        <= ST_FINISH;
          end else if (sel_user) begin
            // The ticket read was issued this cycle; update it next cycle.
            state <= ST_MODIFY;
          end else begin
            state <= ST_SUM;
          end
        end

        ST_MODIFY: begin
          if (item.action == ACT_EXPIRE) begin
            waiting[idx] <= 1'b1;
          end
          state <= ST_SUM;
        end

        ST_SUM: begin
          lag_live <= (cnt < CNT_W'(SLOTS));
          lag_idx  <= cnt[IDX_W-1:0];
          if (elig) begin
            total <= total + SUM_W'(ram_rd_data);
          end
          if (cnt == CNT_W'(SLOTS)) begin
            state <= ST_CHECK;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end

        ST_CHECK: begin
          if (total == '0) begin
            state <= ST_FINISH;
          end else begin
            res.pool_tickets <= pool_sat;
            state            <= ST_DIV;
          end
        end

        ST_DIV: begin
          cnt      <= '0;
          lag_live <= 1'b0;
          if (div_done) begin
            ticket <= div_rem + 1'b1;
            state  <= ST_WALK;
          end
        end

        ST_WALK: begin
          lag_live <= (cnt < CNT_W'(SLOTS));
          lag_idx  <= cnt[IDX_W-1:0];
          if (cnt != CNT_W'(SLOTS)) begin
            cnt <= cnt + 1'b1;
          end
          if (win) begin
            waiting[lag_idx] <= 1'b0;
            res.winner_valid <= 1'b1;
            res.winner_slot  <= win_ext[SLOT_FIELD_W-1:0];
            state            <= ST_FINISH;
          end else begin
            if (elig) begin
              ticket <= ticket - SUM_W'(ram_rd_data);
            end
            if (cnt == CNT_W'(SLOTS)) begin
              state <= ST_FINISH;
            end
          end
        end

        ST_FINISH: begin
          // Hand the result over once the output register is free or draining.
          if (!out_valid || out_ready) begin
            out_item <= res;
            state    <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

  `ASSERT_NEXT(a_accept_decodes, in_valid && in_ready, state == ST_DECODE, "accepted item not decoded")
  `ASSERT_ALWAYS(a_flags_nested, ((waiting & ~is_user) == '0) && ((is_user & ~in_use) == '0), "slot flags inconsistent")
  `ASSERT_NEXT(a_winner_leaves_pool, (state == ST_WALK) && win, !waiting[$past(lag_idx)], "winner still waiting")
  `ASSERT_IMPLY(a_winner_has_pool, out_valid && out_item.winner_valid, (out_item.pool_tickets != '0) && (out_item.status == STAT_OK), "winner without pool")

endmodule

// ===== design/lta_ram.sv =====
// Ticket count memory: one write port, one read port with registered data.
// Depends on nothing beyond its parameters.
`timescale 1ns / 1ps

module lta_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int DW    = 7
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== design/lta_div.sv =====
// Bit-serial restoring modulo unit: one dividend bit per cycle.
// Depends on lta_pkg for the dividend width and on assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lta_div #(
  parameter int DIVISOR_W = 11
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [lta_pkg::RND_W-1:0]  dividend,
  input  logic [DIVISOR_W-1:0]       divisor,
  output logic                       done,
  output logic [DIVISOR_W-1:0]       remainder
);

  import lta_pkg::*;

  localparam int STEP_W = $clog2(RND_W + 1);

  logic                 busy;
  logic [STEP_W-1:0]    steps;
  logic [RND_W-1:0]     num;
  logic [DIVISOR_W-1:0] den;
  logic [DIVISOR_W-1:0] rem_next;
  logic [DIVISOR_W:0]   trial;

  // The partial remainder stays below the divisor, so the trial is below twice it.
  always_comb begin
    trial = {remainder, num[RND_W-1]};
    if (trial >= {1'b0, den}) begin
      rem_next = DIVISOR_W'(trial - {1'b0, den});
    end else begin
      rem_next = trial[DIVISOR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy      <= 1'b1;
        num       <= dividend;
        den       <= divisor;
        remainder <= '0;
        steps     <= STEP_W'(RND_W);
      end else if (busy) begin
        remainder <= rem_next;
        num       <= {num[RND_W-2:0], 1'b0};
        steps     <= steps - 1'b1;
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  `ASSERT_IMPLY(a_div_no_restart, start, !busy, "modulo unit restarted while busy")
  `ASSERT_IMPLY(a_div_rem_range, done, remainder < den, "remainder not below divisor")

endmodule
